FILE: hw/rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern search block.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int PAT_BYTES       = 16;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int ADDR_W          = 48;
  localparam int LEN_W           = 5;
  localparam int LEN_M1_W        = 4;
  localparam int MASK_W          = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW  = 3'd0,
    CFG_PAT_HIGH = 3'd1,
    CFG_WILDCARD = 3'd2,
    CFG_LENGTH   = 3'd3,
    CFG_START    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_range;
  } in_t;

  typedef struct packed {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
    logic              search_done;
  } out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_bytes_low;
    logic [CFG_DATA_W-1:0] pattern_bytes_high;
    logic [MASK_W-1:0]     wildcard_mask;
    logic [LEN_W-1:0]      pattern_length;
    logic [ADDR_W-1:0]     start_address;
  } cfg_t;

endpackage

FILE: hw/rtl/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Byte window, range counters and the parallel masked compare. Produces the
// result of the request being accepted in the same cycle.
// ----------------------------------------------------------------------------
module wbps_match
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  in_t  in_item,
  input  logic fire,
  output out_t result,
  output logic result_valid
);

  localparam int CAP = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;

  logic [7:0]          window      [CAP];
  logic [7:0]          window_next [CAP];
  logic [ADDR_W-1:0]   bytes_seen;
  logic [LEN_M1_W-1:0] skip_count;
  logic [LEN_M1_W-1:0] skip_count_next;

  logic [LEN_M1_W-1:0]    len_m1;
  logic [LEN_M1_W-1:0]    align_shift;
  logic [8*PAT_BYTES-1:0] pat_all;
  logic [8*PAT_BYTES-1:0] pat_rev;
  logic [8*PAT_BYTES-1:0] pat_aligned;
  logic [MASK_W-1:0]      wild_rev;
  logic [MASK_W-1:0]      wild_aligned;
  logic [CAP-1:0]         lane_ok;
  logic                   too_early;
  logic                   hit;
  logic [ADDR_W-1:0]      match_addr;

  // effective length minus one: zero counts as one, saturate at CAP
  always_comb begin
    priority if (cfg.pattern_length == '0) begin
      len_m1 = '0;
    end else if (cfg.pattern_length > LEN_W'(CAP)) begin
      len_m1 = LEN_M1_W'(CAP - 1);
    end else begin
      len_m1 = LEN_M1_W'(cfg.pattern_length - LEN_W'(1));
    end
  end

  // Pattern byte k must sit at window position len-1-k: reverse the byte
  // order, then shift down by 16-len bytes.
  assign pat_all     = {cfg.pattern_bytes_high, cfg.pattern_bytes_low};
  assign align_shift = LEN_M1_W'(PAT_BYTES - 1) - len_m1;

  for (genvar r = 0; r < PAT_BYTES; r++) begin : g_rev
    assign pat_rev[8*r +: 8] = pat_all[8*(PAT_BYTES-1-r) +: 8];
    assign wild_rev[r]       = cfg.wildcard_mask[MASK_W-1-r];
  end

  assign pat_aligned  = pat_rev >> {align_shift, 3'b000};
  assign wild_aligned = wild_rev >> align_shift;

  assign window_next[0] = in_item.data_byte;
  for (genvar s = 1; s < CAP; s++) begin : g_shift
    assign window_next[s] = window[s-1];
  end

  for (genvar j = 0; j < CAP; j++) begin : g_lane
    assign lane_ok[j] = (LEN_W'(j) > {1'b0, len_m1}) || wild_aligned[j]
                        || (window_next[j] == pat_aligned[8*j +: 8]);
  end

  // a match needs all of its bytes inside the current range
  assign too_early  = bytes_seen < ADDR_W'(len_m1);
  assign hit        = (&lane_ok) && !too_early && (skip_count == '0);
  assign match_addr = cfg.start_address + bytes_seen - ADDR_W'(len_m1);

  always_comb begin
    if (hit) begin
      skip_count_next = len_m1;
    end else if (skip_count != '0) begin
      skip_count_next = skip_count - LEN_M1_W'(1);
    end else begin
      skip_count_next = skip_count;
    end
  end

  always_comb begin
    result.match_found   = hit;
    result.match_address = hit ? match_addr : '0;
    result.search_done   = in_item.end_of_range;
    result_valid         = hit || in_item.end_of_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '{default: '0};
      bytes_seen <= '0;
      skip_count <= '0;
    end else if (fire) begin
      if (in_item.end_of_range) begin
        window     <= '{default: '0};
        bytes_seen <= '0;
        skip_count <= '0;
      end else begin
        window     <= window_next;
        bytes_seen <= bytes_seen + ADDR_W'(1);
        skip_count <= skip_count_next;
      end
    end
  end

  a_skip_load: assert property (@(posedge clk) disable iff (rst)
    (fire && hit && !in_item.end_of_range) |=> (skip_count == $past(len_m1)))
    else $error("skip count not loaded with length-1 after a match");

  a_range_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && in_item.end_of_range) |=> (bytes_seen == '0 && skip_count == '0))
    else $error("search state not cleared after end of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (fire && hit && !in_item.end_of_range && len_m1 != '0) |=>
      (!hit || $past(cfg.pattern_length) != cfg.pattern_length))
    else $error("overlapping match reported");

endmodule

FILE: hw/rtl/wildcard_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search
// Streams bytes of a memory range and reports non-overlapping matches of a
// configured wildcard byte pattern, plus a done flag on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Configure through cfg_valid/cfg_index/cfg_data (always ready): index 0/1
//   pattern bytes 0-7/8-15, 2 wildcard mask, 3 pattern length, 4 start
//   address. Indexes 5-7 are ignored. Write only while the block is idle.
//   Feed one byte per request on in_valid/in_ready/in_item; set end_of_range
//   on the last byte of the range.
//   A result request appears on out_valid/out_item only for a byte that
//   completes a match or ends the range; other bytes produce nothing.
//   Throughput: one byte per cycle while in_ready is high. Each result is
//   registered in the main output register, or in the skid register.
//   The output has a main register and a skid register, so a byte is still
//   taken in the cycle the receiver stalls; in_ready drops only once the
//   skid register holds a result, and rises again when the receiver takes
//   one.
//   Reset clears the configuration (pattern length 1), the byte window,
//   the range counters and the valid flags of both output registers.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_item
);

  cfg_t cfg;
  logic fire;
  out_t result;
  logic result_valid;
  logic out_fire;
  out_t skid_item;
  logic skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes_low  <= '0;
      cfg.pattern_bytes_high <= '0;
      cfg.wildcard_mask      <= '0;
      cfg.pattern_length     <= LEN_W'(1);
      cfg.start_address      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_PAT_LOW:  cfg.pattern_bytes_low  <= cfg_data;
        CFG_PAT_HIGH: cfg.pattern_bytes_high <= cfg_data;
        CFG_WILDCARD: cfg.wildcard_mask      <= cfg_data[MASK_W-1:0];
        CFG_LENGTH:   cfg.pattern_length     <= cfg_data[LEN_W-1:0];
        CFG_START:    cfg.start_address      <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_valid;
  assign fire     = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  wbps_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_item      (in_item),
    .fire         (fire),
    .result       (result),
    .result_valid (result_valid)
  );

  // main output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (fire && result_valid) begin
      if (!out_valid || out_fire) begin
        out_item  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output is empty");

  a_done_delivered: assert property (@(posedge clk) disable iff (rst)
    (fire && in_item.end_of_range) |=> (out_valid && (out_item.search_done
                                        || skid_item.search_done)))
    else $error("end of range request produced no result");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid register not drained into output");

endmodule

FILE: sim/wildcard_byte_pattern_search_tb.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_tb
// Streams byte ranges into the pattern search block under random sender
// bursts and receiver stalls. A scoreboard keeps its own byte window and
// range counters, predicts the match and done reports for every accepted
// byte, and compares them field by field with what the block returns.
// Directed ranges come first, then random configurations with pattern-rich
// data, partial matches and noise.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wbps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;
  localparam int unsigned RANDOM_BYTES = 1850;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  class match_scoreboard;
    out_t              expected_reports[$];
    logic [63:0]       pat_lo, pat_hi;
    logic [MASK_W-1:0] wild;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] base_addr;
    logic [7:0]        window [PAT_BYTES];
    logic [ADDR_W-1:0] consumed;
    logic [LEN_W-1:0]  holdoff;
    int unsigned       mismatches;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      wild = '0;
      len_reg = 5'd1;
      base_addr = '0;
      mismatches = 0;
      clear_range();
    endfunction

    function void clear_range();
      foreach (window[k]) window[k] = 8'h00;
      consumed = '0;
      holdoff = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_PAT_LOW:  pat_lo = d;
        CFG_PAT_HIGH: pat_hi = d;
        CFG_WILDCARD: wild = d[MASK_W-1:0];
        CFG_LENGTH:   len_reg = d[LEN_W-1:0];
        CFG_START:    base_addr = d[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(in_t item);
      int unsigned   cap, n, k;
      logic [127:0]  pat;
      logic          hit;
      out_t          rep;
      cap = (MAX_PATTERN_DEF < PAT_BYTES) ? MAX_PATTERN_DEF : PAT_BYTES;
      n = len_reg;
      if (n == 0) n = 1;
      if (n > cap) n = cap;
      for (k = PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = item.data_byte;
      pat = {pat_hi, pat_lo};
      // a match must lie inside the range and not overlap the previous one
      hit = (consumed >= ADDR_W'(n - 1)) && (holdoff == 0);
      for (k = 0; k < n; k++)
        if (!wild[k] && window[n-1-k] != pat[8*k +: 8]) hit = 1'b0;
      rep = '0;
      rep.match_found = hit;
      if (hit) begin
        rep.match_address = base_addr + consumed - ADDR_W'(n - 1);
        holdoff = LEN_W'(n - 1);
      end else if (holdoff != 0) begin
        holdoff--;
      end
      consumed++;
      rep.search_done = item.end_of_range;
      if (item.end_of_range) clear_range();
      if (hit || item.end_of_range) expected_reports = {expected_reports, rep};
    endfunction

    function void compare(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: match_found %0d match_address %0h search_done %0d",
               got.match_found, got.match_address, got.search_done);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      compare("match_found", ADDR_W'(want.match_found), ADDR_W'(got.match_found));
      compare("match_address", want.match_address, got.match_address);
      compare("search_done", ADDR_W'(want.search_done), ADDR_W'(got.search_done));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_item;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_t                  out_item;

  match_scoreboard sb = new();

  // stimulus generator's view of the pattern currently loaded
  logic [127:0]      g_pat;
  logic [MASK_W-1:0] g_mask;
  int unsigned       g_len;
  logic [7:0]        alpha [4];
  int unsigned       alpha_span;
  int unsigned       end_odds;
  int unsigned       tx_gap_max = 0;
  int unsigned       rx_mode = 0;
  int unsigned       rx_hold = 0;
  int unsigned       bytes_sent = 0;
  in_t               range_bytes[$];

  wildcard_byte_pattern_search u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_report(out_item);
      if (in_valid && in_ready) sb.note_byte(in_item);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // receiver: ready runs and stall runs, stall length set by rx_mode
  always @(negedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (!out_ready || rx_mode == 0) begin
      out_ready <= 1'b1;
      rx_hold <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b0;
      rx_hold <= (rx_mode == 1) ? $urandom_range(0, 2) : $urandom_range(3, 20);
    end
  end

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(input in_t b);
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle(input int unsigned settle);
    int unsigned n;
    n = 0;
    @(negedge clk);
    while (sb.expected_reports.size() != 0 && n < 5000) begin
      @(negedge clk);
      n++;
    end
    if (sb.expected_reports.size() != 0) begin
      $error("%0d expected reports never arrived", sb.expected_reports.size());
      sb.mismatches += sb.expected_reports.size();
      sb.expected_reports.delete();
    end
    repeat (settle) @(negedge clk);
  endtask

  // sends range_bytes in bursts, then waits for every report
  task automatic run_range();
    int unsigned idx, burst, gap, j;
    idx = 0;
    while (idx < range_bytes.size()) begin
      burst = $urandom_range(1, 16);
      for (j = 0; j < burst && idx < range_bytes.size(); j++) begin
        push_byte(range_bytes[idx]);
        idx++;
      end
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    bytes_sent += range_bytes.size();
    range_bytes.delete();
    wait_idle(4);
  endtask

  function automatic void add_byte(logic [7:0] b, logic last);
    in_t item;
    item.data_byte = b;
    item.end_of_range = last;
    range_bytes = {range_bytes, item};
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : alpha[$urandom_range(0, alpha_span)];
    return b;
  endfunction

  function automatic logic random_end();
    return $urandom_range(1, end_odds) == 1;
  endfunction

  task automatic random_phase();
    int unsigned      n, r, k, p, len_val;
    logic             noisy;
    logic [CFG_DATA_W-1:0] d;
    logic [ADDR_W-1:0] start;

    alpha[0] = 8'h00;
    alpha[1] = 8'hFF;
    alpha[2] = 8'($urandom);
    alpha[3] = 8'($urandom);
    alpha_span = $urandom_range(1, 3);
    for (k = 0; k < PAT_BYTES; k++) g_pat[8*k +: 8] = pick_byte();

    r = $urandom_range(0, 9);
    case (r)
      0: len_val = 1;
      1: len_val = 16;
      2: len_val = 0;
      3: len_val = $urandom_range(17, 31);
      4: len_val = 2;
      default: len_val = $urandom_range(1, 8);
    endcase
    g_len = (len_val == 0) ? 1 : (len_val > 16 ? 16 : len_val);

    r = $urandom_range(0, 5);
    g_mask = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom & $urandom);

    noisy = 1'($urandom_range(0, 1));
    write_cfg(CFG_PAT_LOW, g_pat[63:0]);
    write_cfg(CFG_PAT_HIGH, g_pat[127:64]);
    d = noisy ? {$urandom, $urandom} : '0;
    d[MASK_W-1:0] = g_mask;
    write_cfg(CFG_WILDCARD, d);
    d = noisy ? {$urandom, $urandom} : '0;
    d[LEN_W-1:0] = LEN_W'(len_val);
    write_cfg(CFG_LENGTH, d);
    if ($urandom_range(0, 1) == 0) begin
      r = $urandom_range(0, 3);
      start = (r == 0) ? '0 : (r == 1) ? ADDR_MAX :
              (r == 2) ? ADDR_MAX - ADDR_W'($urandom_range(0, 40)) :
              ADDR_W'({$urandom, $urandom});
      d = noisy ? {$urandom, $urandom} : '0;
      d[ADDR_W-1:0] = start;
      write_cfg(CFG_START, d);
    end
    if ($urandom_range(0, 7) == 0)
      write_cfg(3'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), {$urandom, $urandom});

    rx_mode = $urandom_range(0, 2);
    r = $urandom_range(0, 2);
    tx_gap_max = (r == 0) ? 0 : (r == 1) ? 3 : 12;
    end_odds = $urandom_range(0, 1) ? 8 : 70;

    n = $urandom_range(15, 110);
    while (range_bytes.size() < n) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        for (k = 0; k < g_len; k++)
          add_byte(g_mask[k] ? pick_byte() : g_pat[8*k +: 8], random_end());
      end else if (r == 5 && g_len > 1) begin
        // prefix of the pattern, then a byte that most likely breaks it
        p = $urandom_range(1, g_len - 1);
        for (k = 0; k < p; k++) add_byte(g_pat[8*k +: 8], random_end());
        add_byte(pick_byte(), random_end());
      end else if (r < 9) begin
        add_byte(pick_byte(), random_end());
      end else begin
        add_byte(8'($urandom), random_end());
      end
    end
    // half the phases leave the range open across the next register writes
    range_bytes[range_bytes.size()-1].end_of_range = 1'($urandom_range(0, 1));
    run_range();
  endtask

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration: one pattern byte 0x00
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b1);
    add_byte(8'h00, 1'b1);
    run_range();

    // three-byte pattern with a wildcard middle; addresses wrap past the top
    write_cfg(CFG_PAT_LOW, 64'h0000_0000_00EF_CDAB);
    write_cfg(CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CFG_WILDCARD, 64'h0000_0000_0000_0002);
    write_cfg(CFG_LENGTH, 64'd3);
    write_cfg(CFG_START, 64'h0000_FFFF_FFFF_FFFE);
    rx_mode = 2;
    tx_gap_max = 3;
    add_byte(8'hAB, 1'b0);
    add_byte(8'h11, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'hAB, 1'b0);
    add_byte(8'h22, 1'b0);
    add_byte(8'hEF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hAB, 1'b0);
    add_byte(8'h33, 1'b0);
    add_byte(8'hEF, 1'b1);
    run_range();

    // zero bytes left in the cleared window must not match at range start
    write_cfg(CFG_PAT_LOW, 64'h0);
    write_cfg(CFG_WILDCARD, 64'hFFFF_FFFF_FFFF_0004);
    write_cfg(CFG_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
    rx_mode = 1;
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h09, 1'b1);
    run_range();

    // length zero behaves as length one
    write_cfg(CFG_LENGTH, 64'd0);
    write_cfg(CFG_WILDCARD, 64'd0);
    add_byte(8'h00, 1'b1);
    run_range();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) random_phase();

    wait_idle(8);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
